/* rtl/prl_pkg.sv */
// Shared types and codes for the positional record list.
// Used by the front, queue, back and top-level modules; depends on nothing.
package prl_pkg;

  // Default list capacity in records.
  localparam int PRL_DEPTH = 16;

  // Command codes as they arrive on the command channel.
  localparam logic [2:0] CMD_APPEND    = 3'd0;
  localparam logic [2:0] CMD_INSERT    = 3'd1;
  localparam logic [2:0] CMD_DELETE    = 3'd2;
  localparam logic [2:0] CMD_FIND_ID   = 3'd3;
  localparam logic [2:0] CMD_FIND_NAME = 3'd4;
  localparam logic [2:0] CMD_CLEAR     = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  // Operation classes handed from the front to the back.
  typedef enum logic [2:0] {
    OP_PUT,
    OP_DELETE,
    OP_FIND_ID,
    OP_FIND_NAME,
    OP_CLEAR,
    OP_BAD
  } op_kind_t;

  // One stored record.
  typedef struct packed {
    logic signed [31:0] id;
    logic [63:0]        name_head;
    logic [7:0]         name_tail;
    logic signed [31:0] salary;
  } rec_t;

  // One classified command.
  typedef struct packed {
    op_kind_t    kind;
    logic        insert;
    logic [7:0]  position;
    rec_t        rec;
  } op_t;

endpackage

/* rtl/prl_front.sv */
// Front end of the record list: takes command beats, decodes the command
// and brings the name into canonical string form. Depends on prl_pkg.
module prl_front
  import prl_pkg::*;
(
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] emp_id,
  input  logic [63:0]        name_head,
  input  logic [7:0]         name_tail,
  input  logic signed [31:0] salary,
  input  logic [7:0]         position,
  input  logic               queue_full,
  output logic               push,
  output op_t                op
);

  logic        live;
  logic [63:0] keep;
  op_kind_t    kind;

  // A name ends at its first zero byte; that byte and all later ones are cleared.
  always_comb begin
    live = 1'b1;
    keep = '0;
    for (int b = 0; b < 8; b++) begin
      if (live && name_head[63 - 8 * b -: 8] == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        keep[63 - 8 * b -: 8] = 8'hFF;
      end
    end
  end

  // Decode the command into an operation class.
  always_comb begin
    unique case (command)
      CMD_APPEND:    kind = OP_PUT;
      CMD_INSERT:    kind = OP_PUT;
      CMD_DELETE:    kind = OP_DELETE;
      CMD_FIND_ID:   kind = OP_FIND_ID;
      CMD_FIND_NAME: kind = OP_FIND_NAME;
      CMD_CLEAR:     kind = OP_CLEAR;
      default:       kind = OP_BAD;
    endcase
  end

  // Build the queue entry and handle the command handshake.
  always_comb begin
    op.kind          = kind;
    op.insert        = (command == CMD_INSERT);
    op.position      = position;
    op.rec.id        = emp_id;
    op.rec.name_head = name_head & keep;
    op.rec.name_tail = live ? name_tail : 8'h00;
    op.rec.salary    = salary;
  end

  assign cmd_stall = queue_full;
  assign push      = cmd_valid && !queue_full;

endmodule

/* rtl/prl_queue.sv */
// Two-entry queue of decoded operations between the front and the back.
// Depends on prl_pkg.
module prl_queue
  import prl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_op    = entries[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

/* rtl/prl_back.sv */
// Back end of the record list: owns the record memory and the fill count,
// walks and shifts records one per cycle, and holds the result beat.
// Depends on prl_pkg.
module prl_back
  import prl_pkg::*;
#(
  parameter int DEPTH = PRL_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  op_t                head_op,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [1:0]         status,
  output logic [3:0]         found_position,
  output logic signed [31:0] found_id,
  output logic [63:0]        found_name_head,
  output logic [7:0]         found_name_tail,
  output logic signed [31:0] found_salary
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_UP     = 6'b000100,
    S_DOWN   = 6'b001000,
    S_PUT    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t          state;
  op_t             cur;
  logic [CW-1:0]   count;
  logic [CW-1:0]   rd_idx;
  logic [CW-1:0]   rd_dec;
  logic [CW-1:0]   at_idx;
  logic [AW-1:0]   wr_idx;
  logic [AW-1:0]   chk_idx;
  logic            rd_pend;
  logic            in_range;
  logic            match;
  logic [1:0]      rs_status;
  logic [3:0]      rs_pos;
  rec_t            rs_rec;

  rec_t            mem [DEPTH];
  rec_t            rdata;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  rec_t            wdata;

  assign rd_dec   = rd_idx - CW'(1);
  assign in_range = (CMPW'(head_op.position) < CMPW'(count));
  assign pop      = (state == S_IDLE) && head_valid;

  // A read beat matches the search key of the current command.
  assign match = (cur.kind == OP_FIND_ID) ? (rdata.id == cur.rec.id)
               : (rdata.name_head == cur.rec.name_head &&
                  rdata.name_tail == cur.rec.name_tail);

  // Memory port steering: one read and one write address per cycle.
  always_comb begin
    raddr = rd_idx[AW-1:0];
    we    = 1'b0;
    waddr = wr_idx;
    wdata = rdata;
    unique case (state)
      S_UP: begin
        raddr = rd_dec[AW-1:0];
        we    = rd_pend;
      end
      S_DOWN: begin
        we = rd_pend;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = at_idx[AW-1:0];
        wdata = cur.rec;
      end
      default: begin
      end
    endcase
  end

  // Record memory with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // The finish state reloads the result register itself.
      if (res_valid && !res_stall && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            cur     <= head_op;
            rd_pend <= 1'b0;
            rs_pos  <= '0;
            rs_rec  <= '0;
            unique case (head_op.kind)
              OP_PUT: begin
                if (count == CW'(DEPTH)) begin
                  rs_status <= ST_FULL;
                  state     <= S_FINISH;
                end else begin
                  rs_status <= ST_MISS;
                  at_idx <= (head_op.insert && in_range) ? CW'(head_op.position) : count;
                  rd_idx <= count;
                  state  <= S_UP;
                end
              end
              OP_DELETE: begin
                rs_status <= ST_MISS;
                if (in_range) begin
                  rd_idx <= CW'(head_op.position) + CW'(1);
                  state  <= S_DOWN;
                end else begin
                  state <= S_FINISH;
                end
              end
              OP_FIND_ID, OP_FIND_NAME: begin
                rs_status <= ST_MISS;
                rd_idx    <= '0;
                state     <= S_SCAN;
              end
              OP_CLEAR: begin
                count     <= '0;
                rs_status <= ST_OK;
                state     <= S_FINISH;
              end
              default: begin
                rs_status <= ST_MISS;
                state     <= S_FINISH;
              end
            endcase
          end
        end

        // Read one record per cycle and compare it in the cycle after its read.
        S_SCAN: begin
          if (rd_pend && match) begin
            rd_pend   <= 1'b0;
            rs_status <= ST_OK;
            rs_pos    <= 4'(chk_idx);
            rs_rec    <= rdata;
            state     <= S_FINISH;
          end else if (rd_idx < count) begin
            chk_idx <= rd_idx[AW-1:0];
            rd_idx  <= rd_idx + CW'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              state <= S_FINISH;
            end
          end
        end

        // Move records one place toward the back, from the end down to the slot.
        S_UP: begin
          if (rd_idx > at_idx) begin
            wr_idx  <= rd_idx[AW-1:0];
            rd_idx  <= rd_dec;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              state <= S_PUT;
            end
          end
        end

        // Move records one place toward the front, closing the deleted slot.
        S_DOWN: begin
          if (rd_idx < count) begin
            wr_idx  <= rd_dec[AW-1:0];
            rd_idx  <= rd_idx + CW'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              count     <= count - CW'(1);
              rs_status <= ST_OK;
              state     <= S_FINISH;
            end
          end
        end

        // Write the new record into its slot.
        S_PUT: begin
          count     <= count + CW'(1);
          rs_status <= ST_OK;
          state     <= S_FINISH;
        end

        // Hand the result to the output register once it is free.
        S_FINISH: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!res_valid || !res_stall)) begin
      status          <= rs_status;
      found_position  <= rs_pos;
      found_id        <= rs_rec.id;
      found_name_head <= rs_rec.name_head;
      found_name_tail <= rs_rec.name_tail;
      found_salary    <= rs_rec.salary;
    end
  end

endmodule

/* rtl/positional_record_list.sv */
// Positional record list top level: front decoder, two-entry queue, back engine.
// The back works one command at a time; a find scans records and an insert or delete
// moves them, one record per cycle. Synchronous reset empties the list, the queue and
// the result register.
module positional_record_list
  import prl_pkg::*;
#(
  parameter int DEPTH = PRL_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] emp_id,
  input  logic [63:0]        name_head,
  input  logic [7:0]         name_tail,
  input  logic signed [31:0] salary,
  input  logic [7:0]         position,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [1:0]         status,
  output logic [3:0]         found_position,
  output logic signed [31:0] found_id,
  output logic [63:0]        found_name_head,
  output logic [7:0]         found_name_tail,
  output logic signed [31:0] found_salary
);

  logic push;
  logic full;
  logic pop;
  logic head_valid;
  op_t  push_op;
  op_t  head_op;

  prl_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .emp_id     (emp_id),
    .name_head  (name_head),
    .name_tail  (name_tail),
    .salary     (salary),
    .position   (position),
    .queue_full (full),
    .push       (push),
    .op         (push_op)
  );

  prl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  prl_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_op         (head_op),
    .pop             (pop),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .status          (status),
    .found_position  (found_position),
    .found_id        (found_id),
    .found_name_head (found_name_head),
    .found_name_tail (found_name_tail),
    .found_salary    (found_salary)
  );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the positional record list.
// Holds a scoreboard class that mirrors the list contents and the drivers for both channels.
// Depends on prl_pkg and the positional_record_list top level only.
module tb;
  import prl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Command codes the block does not define; they must come back as a miss.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

  localparam int RANDOM_ITEMS = 1880;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRESSURE_CYCLES = 400;
  localparam int PRINT_CAP = 50;

  // One command beat and one result beat.
  typedef struct packed {
    logic [2:0] code;
    logic [7:0] position;
    rec_t       rec;
  } command_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] where_at;
    rec_t       rec;
  } outcome_t;

  // Flavors of random traffic.
  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_SEARCH,
    MIX_NOISE
  } mix_t;

  // Tracks the list contents and the results still owed by the block.
  class list_tracker;
    rec_t     recs[PRL_DEPTH];
    int       count;
    outcome_t due[$];
    int       errors;
    int       checked;
    int       op_seen[8];
    int       full_refusals;
    int       find_hits;

    // Clear the first zero byte of a name and everything after it.
    function void tidy_name(inout logic [63:0] head, inout logic [7:0] tail);
      logic ended;
      ended = 1'b0;
      for (int b = 7; b >= 0; b--) begin
        if (head[b*8 +: 8] == 8'h00) ended = 1'b1;
        if (ended) head[b*8 +: 8] = 8'h00;
      end
      if (ended) tail = 8'h00;
    endfunction

    // Apply one accepted command to the list and queue the result it owes.
    function void note_command(command_t c);
      outcome_t r;
      rec_t     key;
      int       at;
      int       hit;
      key = c.rec;
      tidy_name(key.name_head, key.name_tail);
      r = '0;
      r.status = ST_MISS;
      hit = -1;
      op_seen[c.code]++;
      case (c.code)
        CMD_APPEND, CMD_INSERT: begin
          if (count >= PRL_DEPTH) begin
            r.status = ST_FULL;
            full_refusals++;
          end else begin
            at = count;
            if (c.code == CMD_INSERT && int'(c.position) < count) at = int'(c.position);
            for (int i = count; i > at; i--) recs[i] = recs[i-1];
            recs[at] = key;
            count++;
            r.status = ST_OK;
          end
        end
        CMD_DELETE: begin
          if (int'(c.position) < count) begin
            for (int i = int'(c.position); i + 1 < count; i++) recs[i] = recs[i+1];
            count--;
            r.status = ST_OK;
          end
        end
        CMD_FIND_ID, CMD_FIND_NAME: begin
          for (int i = 0; i < count && hit < 0; i++) begin
            if (c.code == CMD_FIND_ID) begin
              if (recs[i].id == key.id) hit = i;
            end else if (recs[i].name_head == key.name_head &&
                         recs[i].name_tail == key.name_tail) begin
              hit = i;
            end
          end
        end
        CMD_CLEAR: begin
          count = 0;
          r.status = ST_OK;
        end
        default: ;
      endcase
      // Only a successful find carries a position and record contents.
      if (hit >= 0) begin
        r.status = ST_OK;
        r.where_at = 4'(hit);
        r.rec = recs[hit];
        find_hits++;
      end
      due.push_back(r);
    endfunction

    function void compare_field(string label, logic [63:0] want, logic [63:0] have);
      if (want !== have) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, have);
      end
    endfunction

    // Compare one accepted result beat against the oldest owed result.
    function void check_outcome(outcome_t got);
      outcome_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: result beat with nothing owed, status %0d", $time, got.status);
        return;
      end
      want = due.pop_front();
      checked++;
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("found_position", 64'(want.where_at), 64'(got.where_at));
      compare_field("found_id", 64'($unsigned(want.rec.id)), 64'($unsigned(got.rec.id)));
      compare_field("found_name_head", want.rec.name_head, got.rec.name_head);
      compare_field("found_name_tail", 64'(want.rec.name_tail), 64'(got.rec.name_tail));
      compare_field("found_salary", 64'($unsigned(want.rec.salary)),
                    64'($unsigned(got.rec.salary)));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  logic [2:0]         command;
  logic signed [31:0] emp_id;
  logic [63:0]        name_head;
  logic [7:0]         name_tail;
  logic signed [31:0] salary;
  logic [7:0]         position;
  logic               res_valid;
  logic               res_stall;
  logic [1:0]         status;
  logic [3:0]         found_position;
  logic signed [31:0] found_id;
  logic [63:0]        found_name_head;
  logic [7:0]         found_name_tail;
  logic signed [31:0] found_salary;

  list_tracker sb;
  int          sent;

  positional_record_list uut (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_stall       (cmd_stall),
    .command         (command),
    .emp_id          (emp_id),
    .name_head       (name_head),
    .name_tail       (name_tail),
    .salary          (salary),
    .position        (position),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .status          (status),
    .found_position  (found_position),
    .found_id        (found_id),
    .found_name_head (found_name_head),
    .found_name_tail (found_name_tail),
    .found_salary    (found_salary)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    // A small pool gives duplicate ids, so first-match order matters.
    if (roll < 50) return $urandom_range(0, 7) - 3;
    if (roll < 55) return WORD_MIN;
    if (roll < 60) return WORD_MAX;
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(65, 67));
    return 8'($urandom_range(1, 255));
  endfunction

  // A name of 0 to 9 characters, sometimes with junk behind its terminator.
  function automatic void pick_name(output logic [63:0] head, output logic [7:0] tail);
    int  len;
    bit  junk;
    len = $urandom_range(0, 9);
    junk = 1'($urandom_range(0, 1));
    head = junk ? {$urandom, $urandom} : 64'h0;
    tail = junk ? 8'($urandom) : 8'h00;
    for (int b = 0; b < 8; b++) begin
      if (b < len) head[(7-b)*8 +: 8] = pick_letter();
      else if (b == len) head[(7-b)*8 +: 8] = 8'h00;
    end
    if (len == 8) tail = 8'h00;
    if (len == 9) tail = pick_letter();
  endfunction

  // Fill every byte behind the terminator with junk; the search must ignore it.
  function automatic void smudge_after_end(inout logic [63:0] head, inout logic [7:0] tail);
    logic ended;
    ended = 1'b0;
    for (int b = 7; b >= 0; b--) begin
      if (ended) head[b*8 +: 8] = 8'($urandom);
      else if (head[b*8 +: 8] == 8'h00) ended = 1'b1;
    end
    if (ended) tail = 8'($urandom);
  endfunction

  function automatic command_t make_cmd(logic [2:0] code, logic signed [31:0] id,
                                        logic [63:0] head, logic [7:0] tail,
                                        logic signed [31:0] pay, logic [7:0] pos);
    command_t c;
    c.code = code;
    c.rec.id = id;
    c.rec.name_head = head;
    c.rec.name_tail = tail;
    c.rec.salary = pay;
    c.position = pos;
    return c;
  endfunction

  // Random command shaped by the traffic flavor and the current list contents.
  function automatic command_t build_random(mix_t mix);
    command_t c;
    int       roll;
    int       cnt;
    int       pick;
    cnt = sb.count;
    roll = $urandom_range(0, 99);
    c.rec.id = pick_id();
    pick_name(c.rec.name_head, c.rec.name_tail);
    c.rec.salary = $urandom;
    if (roll < 5) c.rec.salary = WORD_MIN;
    else if (roll < 10) c.rec.salary = WORD_MAX;
    c.position = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:
        c.code = roll < 40 ? CMD_APPEND : roll < 75 ? CMD_INSERT : roll < 85 ? CMD_FIND_ID :
                 roll < 95 ? CMD_FIND_NAME : CMD_DELETE;
      MIX_SHRINK:
        c.code = roll < 55 ? CMD_DELETE : roll < 70 ? CMD_FIND_ID : roll < 85 ? CMD_FIND_NAME :
                 roll < 95 ? CMD_APPEND : roll < 97 ? CMD_INSERT : CMD_CLEAR;
      MIX_SEARCH:
        c.code = roll < 40 ? CMD_FIND_ID : roll < 80 ? CMD_FIND_NAME : roll < 88 ? CMD_APPEND :
                 roll < 94 ? CMD_INSERT : roll < 99 ? CMD_DELETE : CMD_CLEAR;
      default: begin
        // Raw noise: any code, any bits.
        c.code = 3'($urandom_range(0, 7));
        c.rec.id = $urandom;
        c.rec.name_head = {$urandom, $urandom};
        c.rec.name_tail = 8'($urandom);
        return c;
      end
    endcase
    // Steer positions and keys toward entries that exist.
    roll = $urandom_range(0, 99);
    case (c.code)
      CMD_INSERT: begin
        if (roll < 60) c.position = 8'($urandom_range(0, cnt));
        else if (roll < 75) c.position = 8'h00;
      end
      CMD_DELETE: begin
        if (cnt > 0 && roll < 75) c.position = 8'($urandom_range(0, cnt - 1));
        else if (roll < 85) c.position = 8'(cnt);
      end
      CMD_FIND_ID: begin
        if (cnt > 0 && roll < 70) c.rec.id = sb.recs[$urandom_range(0, cnt - 1)].id;
      end
      CMD_FIND_NAME: begin
        if (cnt > 0 && roll < 70) begin
          pick = $urandom_range(0, cnt - 1);
          c.rec.name_head = sb.recs[pick].name_head;
          c.rec.name_tail = sb.recs[pick].name_tail;
          smudge_after_end(c.rec.name_head, c.rec.name_tail);
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  // Offer one command beat after an optional gap and hold it until taken.
  task automatic send_command(command_t c, int gap);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command   <= c.code;
    emp_id    <= c.rec.id;
    name_head <= c.rec.name_head;
    name_tail <= c.rec.name_tail;
    salary    <= c.rec.salary;
    position  <= c.position;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_command(c);
    sent++;
  endtask

  // Command side: reset, directed cases, random traffic, then drain and report.
  initial begin : command_side
    mix_t mix;
    int   seg_left;
    int   roll;
    bit   calm;
    sb = new;
    sent = 0;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    command   <= CMD_APPEND;
    emp_id    <= '0;
    name_head <= '0;
    name_tail <= '0;
    salary    <= '0;
    position  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty list: delete and search both miss.
    send_command(make_cmd(CMD_DELETE, 0, 64'h0, 8'h00, 0, 8'h00), pick_gap());
    send_command(make_cmd(CMD_FIND_ID, 0, 64'h0, 8'h00, 0, 8'h00), pick_gap());
    // Extreme fields, and a name cut short by a zero byte with junk behind it.
    send_command(make_cmd(CMD_APPEND, WORD_MIN, '1, 8'hFF, WORD_MAX, 8'h00), pick_gap());
    send_command(make_cmd(CMD_APPEND, WORD_MAX, 64'h4142_0055_6677_8899, 8'h5A,
                          WORD_MIN, 8'hFF), pick_gap());
    // Insert at the front with an empty name, past the end, and in the middle.
    send_command(make_cmd(CMD_INSERT, 0, 64'h0, 8'h33, 0, 8'h00), pick_gap());
    send_command(make_cmd(CMD_INSERT, 5, 64'h4A4F_4500_0000_0000, 8'h00, 100, 8'hFF),
                 pick_gap());
    send_command(make_cmd(CMD_INSERT, 7, 64'h4142_4344_4546_4748, 8'h49, -5, 8'h01),
                 pick_gap());
    // Searches: hit by id, hits by name despite junk, full nine-byte names, misses.
    send_command(make_cmd(CMD_FIND_ID, WORD_MAX, 64'h0, 8'h00, 0, 8'h00), pick_gap());
    send_command(make_cmd(CMD_FIND_NAME, 1, 64'h4142_00AA_BBCC_DDEE, 8'h11, 0, 8'h00),
                 pick_gap());
    send_command(make_cmd(CMD_FIND_NAME, 1, 64'h00FF_FFFF_FFFF_FFFF, 8'h01, 0, 8'h00),
                 pick_gap());
    send_command(make_cmd(CMD_FIND_NAME, 1, 64'h4142_4344_4546_4748, 8'h49, 0, 8'h00),
                 pick_gap());
    send_command(make_cmd(CMD_FIND_NAME, 1, 64'h4142_4344_4546_4748, 8'h00, 0, 8'h00),
                 pick_gap());
    send_command(make_cmd(CMD_FIND_ID, 12345, 64'h0, 8'h00, 0, 8'h00), pick_gap());
    // Deletes out of range, then one in the middle.
    send_command(make_cmd(CMD_DELETE, 0, 64'h0, 8'h00, 0, 8'hFF), pick_gap());
    send_command(make_cmd(CMD_DELETE, 0, 64'h0, 8'h00, 0, 8'd5), pick_gap());
    send_command(make_cmd(CMD_DELETE, 0, 64'h0, 8'h00, 0, 8'd1), pick_gap());
    // Undefined command codes leave the list alone.
    send_command(make_cmd(CMD_SPARE_6, 1, 64'h0, 8'h00, 0, 8'h00), pick_gap());
    send_command(make_cmd(CMD_SPARE_7, 1, 64'h0, 8'h00, 0, 8'h00), pick_gap());
    // Clear, then delete on the emptied list, then delete of the only record.
    send_command(make_cmd(CMD_CLEAR, 0, 64'h0, 8'h00, 0, 8'h00), pick_gap());
    send_command(make_cmd(CMD_DELETE, 0, 64'h0, 8'h00, 0, 8'h00), pick_gap());
    send_command(make_cmd(CMD_APPEND, 9, 64'h5A00_0000_0000_0000, 8'h00, 9, 8'h00),
                 pick_gap());
    send_command(make_cmd(CMD_DELETE, 0, 64'h0, 8'h00, 0, 8'h00), pick_gap());
    send_command(make_cmd(CMD_FIND_ID, 9, 64'h0, 8'h00, 0, 8'h00), pick_gap());

    // Random traffic in segments of one flavor; some segments run without gaps.
    seg_left = 0;
    mix = MIX_GROW;
    calm = 1'b0;
    repeat (RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(30, 60);
        roll = $urandom_range(0, 99);
        mix = roll < 30 ? MIX_GROW : roll < 55 ? MIX_SHRINK : roll < 88 ? MIX_SEARCH :
              MIX_NOISE;
        calm = ($urandom_range(0, 4) == 0);
      end
      seg_left--;
      send_command(build_random(mix), calm ? 0 : pick_gap());
    end
    cmd_valid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands: append %0d, insert %0d, delete %0d, find id %0d, find name %0d,",
             sent, sb.op_seen[CMD_APPEND], sb.op_seen[CMD_INSERT], sb.op_seen[CMD_DELETE],
             sb.op_seen[CMD_FIND_ID], sb.op_seen[CMD_FIND_NAME]);
    $display("clear %0d, undefined %0d; %0d results checked, %0d full refusals, %0d find hits",
             sb.op_seen[CMD_CLEAR], sb.op_seen[CMD_SPARE_6] + sb.op_seen[CMD_SPARE_7],
             sb.checked, sb.full_refusals, sb.find_hits);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result side: check each accepted beat and stall at random, with two long holds.
  initial begin : result_side
    outcome_t got;
    int       hold;
    int       calm_left;
    int       holds_done;
    int       roll;
    bit       calm;
    hold = 0;
    calm_left = 0;
    holds_done = 0;
    calm = 1'b0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        got.status = status;
        got.where_at = found_position;
        got.rec.id = found_id;
        got.rec.name_head = found_name_head;
        got.rec.name_tail = found_name_tail;
        got.rec.salary = found_salary;
        sb.check_outcome(got);
      end
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 300);
      end else begin
        calm_left--;
      end
      // Long hold-offs let the queue fill so the block stalls its command side.
      if (hold == 0 && ((holds_done == 0 && sb.checked >= 300) ||
                        (holds_done == 1 && sb.checked >= 1200))) begin
        hold = PRESSURE_CYCLES;
        holds_done++;
      end else if (hold == 0 && !calm) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) hold = 0;
        else if (roll < 95) hold = $urandom_range(1, 4);
        else hold = $urandom_range(15, 60);
      end
      if (hold > 0) begin
        res_stall <= 1'b1;
        hold--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no beat accepted for %0d cycles, %0d results still owed",
             IDLE_LIMIT, sb.due.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
